@@ rtl/dorm_pkg.sv @@
// dorm_pkg: shared widths, codes and the per-core share table for the
// open-row dram access model; depends on nothing
package dorm_pkg;

   // default geometry
   localparam int unsigned DEF_ROW_COUNT     = 1024;
   localparam int unsigned DEF_WORDS_PER_ROW = 256;

   // fixed field widths
   localparam int unsigned SPACE_W   = 20;           // byte address space
   localparam int unsigned WORD_W    = SPACE_W - 2;  // word index
   localparam int unsigned CORE_W    = 4;
   localparam int unsigned CORES_W   = 5;            // core_count register
   localparam int unsigned MAX_CORES = 16;
   localparam int unsigned DATA_W    = 32;
   localparam int unsigned LAT_W     = 12;
   localparam int unsigned DELAY_W   = 10;
   localparam int unsigned COUNT_W   = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 10;
   localparam int unsigned SHARE_W   = SPACE_W + 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROW_DELAY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COL_DELAY  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CORE_COUNT = 2'd2;

   // register reset values
   localparam logic [DELAY_W-1:0] RST_ROW_DELAY  = 10'd10;
   localparam logic [DELAY_W-1:0] RST_COL_DELAY  = 10'd2;
   localparam logic [CORES_W-1:0] RST_CORE_COUNT = 5'd1;

   // access codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   // bytes per core for 1..16 cores (entry i is for i+1 cores)
   localparam logic [SHARE_W-1:0] SHARE_TABLE [MAX_CORES] = '{
      21'd1048576, 21'd524288, 21'd349525, 21'd262144,
      21'd209715,  21'd174762, 21'd149796, 21'd131072,
      21'd116508,  21'd104857, 21'd95325,  21'd87381,
      21'd80659,   21'd74898,  21'd69905,  21'd65536
   };

endpackage

@@ rtl/dorm_ram.sv @@
// dorm_ram: generic single-port synchronous ram with registered read
// depends on nothing
module dorm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/dorm_cdiv.sv @@
// dorm_cdiv: two-stage divider by a constant (reciprocal multiply, then
// one compare-and-subtract correction); depends on nothing
module dorm_cdiv #(
   parameter int unsigned IN_W    = 18,
   parameter int unsigned DIVISOR = 256
) (
   input  logic                       clock,
   input  logic [IN_W-1:0]            in_value,
   output logic [IN_W-1:0]            quot,
   output logic [$clog2(DIVISOR)-1:0] rem
);

   localparam int unsigned    REM_W   = $clog2(DIVISOR);
   localparam longint unsigned RECIP_L = (64'd1 << IN_W) / DIVISOR;
   localparam logic [IN_W-1:0] RECIP   = RECIP_L[IN_W-1:0];
   localparam logic [IN_W-1:0] DIV_V   = IN_W'(DIVISOR);

   logic [2*IN_W-1:0] prod_ff, prod_in;
   logic [IN_W-1:0]   x_ff;
   logic [IN_W-1:0]   q_est, qd, r_est;
   logic              fix;
   logic [IN_W-1:0]   quot_ff, quot_in;
   logic [REM_W-1:0]  rem_ff, rem_in;

   // estimate is low by at most one
   assign prod_in = (2*IN_W)'(in_value) * (2*IN_W)'(RECIP);

   always_comb begin
      q_est   = prod_ff[2*IN_W-1:IN_W];
      qd      = q_est * DIV_V;
      r_est   = x_ff - qd;
      fix     = (r_est >= DIV_V);
      quot_in = q_est + IN_W'(fix);
      rem_in  = fix ? REM_W'(r_est - DIV_V) : REM_W'(r_est);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      x_ff    <= in_value;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

@@ rtl/dram_open_row_access_model.sv @@
// dram_open_row_access_model: open-page dram timing model over a word memory
// uses dorm_pkg, dorm_ram (word memory) and dorm_cdiv (row/column split)
// a beat passes the two constant dividers (skipped with power-of-two geometry),
// the word memory read and the output register; a new beat is taken only while
// idle or as the previous result moves to the output
// reset: a clearing pass zeroes all ROW_COUNT*WORDS_PER_ROW words of the memory
module dram_open_row_access_model #(
   parameter int unsigned ROW_COUNT     = dorm_pkg::DEF_ROW_COUNT,
   parameter int unsigned WORDS_PER_ROW = dorm_pkg::DEF_WORDS_PER_ROW
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_write_enable,
   input  logic [dorm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dorm_pkg::CSR_DAT_W-1:0]        csr_write_data,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic [dorm_pkg::CORE_W-1:0]           req_core_id,
   input  logic [dorm_pkg::SPACE_W-1:0]          req_local_address,
   input  logic signed [dorm_pkg::DATA_W-1:0]    req_store_data,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [dorm_pkg::DATA_W-1:0]    rsp_read_data,
   output logic [dorm_pkg::LAT_W-1:0]            rsp_latency,
   output logic                                  rsp_row_activated,
   output logic                                  rsp_address_error,
   output logic [dorm_pkg::COUNT_W-1:0]          rsp_activation_count,
   output logic [dorm_pkg::COUNT_W-1:0]          rsp_store_count
);

   import dorm_pkg::*;

   // geometry
   localparam int unsigned ROW_W  = $clog2(ROW_COUNT);
   localparam int unsigned COL_W  = $clog2(WORDS_PER_ROW);
   localparam int unsigned DEPTH  = ROW_COUNT * WORDS_PER_ROW;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   // power-of-two geometry needs no dividers
   localparam bit FAST = ((1 << ROW_W) == ROW_COUNT) && ((1 << COL_W) == WORDS_PER_ROW);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(WORDS_PER_ROW);

   // divider pipeline: two dividers of two stages each
   localparam int unsigned DIV_LAT   = 4;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_LAT);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_LAT - 1);

   // sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_MEM   = 3'd3;
   localparam logic [2:0] ST_WAIT  = 3'd4;
   localparam logic [2:0] ST_ENTER = FAST ? ST_MEM : ST_DIV;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   logic [2:0]            state_ff, state_in;
   logic [ADDR_W-1:0]     clear_addr_ff, clear_addr_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;

   logic [DELAY_W-1:0]    row_delay_ff, row_delay_in;
   logic [DELAY_W-1:0]    col_delay_ff, col_delay_in;
   logic [CORES_W-1:0]    core_count_ff, core_count_in;

   // accepted beat
   logic                  op_ff, op_in;
   logic                  err_ff, err_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [DATA_W-1:0]     data_ff, data_in;

   // open row tracking and running counts
   logic [ROW_W-1:0]      open_row_ff, open_row_in;
   logic                  row_valid_ff, row_valid_in;
   logic [COUNT_W-1:0]    act_cnt_ff, act_cnt_in;
   logic [COUNT_W-1:0]    store_cnt_ff, store_cnt_in;

   // result staged while the memory read is in flight
   logic [LAT_W-1:0]      st_lat_ff, st_lat_in;
   logic                  st_act_ff, st_act_in;
   logic                  st_err_ff, st_err_in;
   logic                  st_load_ff, st_load_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_read_data_ff, rsp_read_data_in;
   logic [LAT_W-1:0]      rsp_latency_ff, rsp_latency_in;
   logic                  rsp_act_ff, rsp_act_in;
   logic                  rsp_err_ff, rsp_err_in;
   logic [COUNT_W-1:0]    rsp_act_cnt_ff, rsp_act_cnt_in;
   logic [COUNT_W-1:0]    rsp_store_cnt_ff, rsp_store_cnt_in;

   // ---------------------------------------------------------------------
   // request decode: share of each core, range check, global word index
   // ---------------------------------------------------------------------
   logic [CORES_W-1:0]         cores_eff;
   logic [SHARE_W-1:0]         share;
   logic [CORE_W+SHARE_W-1:0]  base;
   logic [SPACE_W-1:0]         global_addr;
   logic                       addr_bad;

   always_comb begin
      // zero cores behaves as one, more than sixteen as sixteen
      if (core_count_ff == '0) begin
         cores_eff = CORES_W'(1);
      end else if (core_count_ff > CORES_W'(MAX_CORES)) begin
         cores_eff = CORES_W'(MAX_CORES);
      end else begin
         cores_eff = core_count_ff;
      end
      share       = SHARE_TABLE[CORE_W'(cores_eff - CORES_W'(1))];
      base        = (CORE_W+SHARE_W)'(req_core_id) * (CORE_W+SHARE_W)'(share);
      global_addr = SPACE_W'(base) + req_local_address;
      addr_bad    = ({1'b0, req_local_address} >= share) ||
                    ({1'b0, req_core_id} >= cores_eff);
   end

   // ---------------------------------------------------------------------
   // row and column of the word
   // ---------------------------------------------------------------------
   logic [WORD_W-1:0] div_qw;
   logic [COL_W-1:0]  div_col;
   logic [ROW_W-1:0]  div_row;
   logic [ROW_W-1:0]  row_sel;
   logic [COL_W-1:0]  col_sel;
   logic [ADDR_W-1:0] mem_addr;

   // word / WORDS_PER_ROW gives row index and column
   dorm_cdiv #(
      .IN_W    (WORD_W),
      .DIVISOR (WORDS_PER_ROW)
   ) u_div_col (
      .clock    (clock),
      .in_value (word_ff),
      .quot     (div_qw),
      .rem      (div_col)
   );

   // row index wraps over the row count
   dorm_cdiv #(
      .IN_W    (WORD_W),
      .DIVISOR (ROW_COUNT)
   ) u_div_row (
      .clock    (clock),
      .in_value (div_qw),
      .quot     (),
      .rem      (div_row)
   );

   always_comb begin
      row_sel  = FAST ? ROW_W'(word_ff >> COL_W) : div_row;
      col_sel  = FAST ? COL_W'(word_ff) : div_col;
      mem_addr = ADDR_W'(row_sel) * ROW_STEP + ADDR_W'(col_sel);
   end

   // ---------------------------------------------------------------------
   // word memory
   // ---------------------------------------------------------------------
   logic              ram_en, ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   dorm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_word_mem (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         // clearing pass writes zero one word a cycle
         ram_en    = 1'b1;
         ram_we    = 1'b1;
         ram_addr  = clear_addr_ff;
         ram_wdata = '0;
      end else begin
         ram_en    = (state_ff == ST_MEM) && !err_ff;
         ram_we    = (op_ff == OP_STORE);
         ram_addr  = mem_addr;
         ram_wdata = data_ff;
      end
   end

   // ---------------------------------------------------------------------
   // handshake
   // ---------------------------------------------------------------------
   logic rsp_free;
   logic req_accept;
   logic row_miss;

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   // take a new beat when idle, or as the previous result moves to the output
   assign req_ready  = (state_ff == ST_IDLE) || ((state_ff == ST_WAIT) && rsp_free);
   assign req_accept = req_valid && req_ready;
   assign row_miss   = !row_valid_ff || (row_sel != open_row_ff);

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in         = state_ff;
      clear_addr_in    = clear_addr_ff;
      div_cnt_in       = '0;

      row_delay_in     = row_delay_ff;
      col_delay_in     = col_delay_ff;
      core_count_in    = core_count_ff;

      op_in            = op_ff;
      err_in           = err_ff;
      word_in          = word_ff;
      data_in          = data_ff;

      open_row_in      = open_row_ff;
      row_valid_in     = row_valid_ff;
      act_cnt_in       = act_cnt_ff;
      store_cnt_in     = store_cnt_ff;

      st_lat_in        = st_lat_ff;
      st_act_in        = st_act_ff;
      st_err_in        = st_err_ff;
      st_load_in       = st_load_ff;

      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_read_data_in = rsp_read_data_ff;
      rsp_latency_in   = rsp_latency_ff;
      rsp_act_in       = rsp_act_ff;
      rsp_err_in       = rsp_err_ff;
      rsp_act_cnt_in   = rsp_act_cnt_ff;
      rsp_store_cnt_in = rsp_store_cnt_ff;

      // configuration writes are taken in every state
      if (csr_write_enable) begin
         case (csr_index)
            REG_ROW_DELAY:  row_delay_in  = csr_write_data;
            REG_COL_DELAY:  col_delay_in  = csr_write_data;
            REG_CORE_COUNT: core_count_in = CORES_W'(csr_write_data);
            default: ;
         endcase
      end

      // capture the accepted beat
      if (req_accept) begin
         op_in   = req_op;
         err_in  = addr_bad;
         word_in = global_addr[SPACE_W-1:2];
         data_in = req_store_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_ENTER;
            end
         end
         ST_DIV: begin
            // wait for the divider pipeline to settle on this word
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_MEM;
            end
         end
         ST_MEM: begin
            // memory access issued; resolve row buffer and counts
            st_err_in  = err_ff;
            st_load_in = !err_ff && (op_ff == OP_LOAD);
            st_act_in  = 1'b0;
            st_lat_in  = '0;
            if (!err_ff) begin
               st_lat_in = LAT_W'(col_delay_ff);
               if (row_miss) begin
                  // activate, plus write back of the row that was open
                  st_lat_in = LAT_W'(col_delay_ff) + LAT_W'(row_delay_ff) +
                              (row_valid_ff ? LAT_W'(row_delay_ff) : LAT_W'(0));
                  st_act_in    = 1'b1;
                  open_row_in  = row_sel;
                  row_valid_in = 1'b1;
                  act_cnt_in   = act_cnt_ff + COUNT_W'(1);
               end
               if (op_ff == OP_STORE) begin
                  store_cnt_in = store_cnt_ff + COUNT_W'(1);
               end
            end
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            // read data is back; move result to the output register
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_read_data_in = st_load_ff ? ram_rdata : '0;
               rsp_latency_in   = st_lat_ff;
               rsp_act_in       = st_act_ff;
               rsp_err_in       = st_err_ff;
               rsp_act_cnt_in   = act_cnt_ff;
               rsp_store_cnt_in = store_cnt_ff;
               state_in         = req_accept ? ST_ENTER : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         div_cnt_ff    <= '0;
         row_delay_ff  <= RST_ROW_DELAY;
         col_delay_ff  <= RST_COL_DELAY;
         core_count_ff <= RST_CORE_COUNT;
         open_row_ff   <= '0;
         row_valid_ff  <= 1'b0;
         act_cnt_ff    <= '0;
         store_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         div_cnt_ff    <= div_cnt_in;
         row_delay_ff  <= row_delay_in;
         col_delay_ff  <= col_delay_in;
         core_count_ff <= core_count_in;
         open_row_ff   <= open_row_in;
         row_valid_ff  <= row_valid_in;
         act_cnt_ff    <= act_cnt_in;
         store_cnt_ff  <= store_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      err_ff           <= err_in;
      word_ff          <= word_in;
      data_ff          <= data_in;
      st_lat_ff        <= st_lat_in;
      st_act_ff        <= st_act_in;
      st_err_ff        <= st_err_in;
      st_load_ff       <= st_load_in;
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_latency_ff   <= rsp_latency_in;
      rsp_act_ff       <= rsp_act_in;
      rsp_err_ff       <= rsp_err_in;
      rsp_act_cnt_ff   <= rsp_act_cnt_in;
      rsp_store_cnt_ff <= rsp_store_cnt_in;
   end

   // outputs
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_read_data        = rsp_read_data_ff;
   assign rsp_latency          = rsp_latency_ff;
   assign rsp_row_activated    = rsp_act_ff;
   assign rsp_address_error    = rsp_err_ff;
   assign rsp_activation_count = rsp_act_cnt_ff;
   assign rsp_store_count      = rsp_store_cnt_ff;

endmodule

@@ rtl/dorm_checker.sv @@
// dorm_checker: port-level checks on the dram access model, bound to the top
// uses dorm_pkg
module dorm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [dorm_pkg::DATA_W-1:0]  rsp_read_data,
   input logic [dorm_pkg::LAT_W-1:0]          rsp_latency,
   input logic                                rsp_row_activated,
   input logic                                rsp_address_error
);

   import dorm_pkg::*;

   // beats taken but not yet answered
   logic [1:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + 2'd1;
      end else if (!(req_valid && req_ready) && rsp_valid && rsp_ready) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
      $stable(rsp_latency))
      else $error("response changed while stalled");

   // a rejected access reports nothing
   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_address_error |->
      rsp_read_data == '0 && rsp_latency == '0 && !rsp_row_activated)
      else $error("address error with non-zero result");

   // every response answers a request, at most two in flight
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without request");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many requests in flight");

   // memory clearing keeps the request side closed after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

endmodule

bind dram_open_row_access_model dorm_checker u_dorm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_read_data     (rsp_read_data),
   .rsp_latency       (rsp_latency),
   .rsp_row_activated (rsp_row_activated),
   .rsp_address_error (rsp_address_error)
);

@@ verif/dorm_access_checker.sv @@
// dorm_access_checker: watches the request, response and register ports of the
// open-row dram access model, predicts every response and compares it
// depends on dorm_pkg
module dorm_access_checker #(
   parameter int unsigned ROW_COUNT     = dorm_pkg::DEF_ROW_COUNT,
   parameter int unsigned WORDS_PER_ROW = dorm_pkg::DEF_WORDS_PER_ROW
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [dorm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dorm_pkg::CSR_DAT_W-1:0]       csr_write_data,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [dorm_pkg::CORE_W-1:0]          req_core_id,
   input  logic [dorm_pkg::SPACE_W-1:0]         req_local_address,
   input  logic signed [dorm_pkg::DATA_W-1:0]   req_store_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [dorm_pkg::DATA_W-1:0]   rsp_read_data,
   input  logic [dorm_pkg::LAT_W-1:0]           rsp_latency,
   input  logic                                 rsp_row_activated,
   input  logic                                 rsp_address_error,
   input  logic [dorm_pkg::COUNT_W-1:0]         rsp_activation_count,
   input  logic [dorm_pkg::COUNT_W-1:0]         rsp_store_count,
   output int                                   mismatches,
   output int                                   outstanding,
   output int                                   responses,
   output int                                   address_errors,
   output int                                   row_opens,
   output int                                   stores_done
);

   import dorm_pkg::*;

   localparam int unsigned WORDS_TOTAL = ROW_COUNT * WORDS_PER_ROW;

   typedef struct packed {
      logic [DATA_W-1:0]  read_data;
      logic [LAT_W-1:0]   latency;
      logic               row_activated;
      logic               address_error;
      logic [COUNT_W-1:0] activation_count;
      logic [COUNT_W-1:0] store_count;
   } access_result_type;

   // shadow of the block: registers, open row and the word memory
   logic [DELAY_W-1:0] row_delay_q;
   logic [DELAY_W-1:0] col_delay_q;
   logic [CORES_W-1:0] core_count_q;
   logic [9:0]         open_row_q;
   logic               row_open_q;
   logic [COUNT_W-1:0] activations_q;
   logic [COUNT_W-1:0] stores_q;
   logic [DATA_W-1:0]  shadow_words [int unsigned];

   access_result_type pending_results [$];
   int mismatch_tally;
   int response_tally;
   int reject_tally;

   function automatic access_result_type predict_access(input logic op,
                                                        input logic [CORE_W-1:0] core,
                                                        input logic [SPACE_W-1:0] local_addr,
                                                        input logic [DATA_W-1:0] data);
      access_result_type r;
      int unsigned cores;
      int unsigned share;
      int unsigned global_addr;
      int unsigned word_idx;
      int unsigned row;
      int unsigned lat;
      r = '0;
      lat = 0;
      cores = (core_count_q == '0) ? 1 :
              (core_count_q > CORES_W'(MAX_CORES)) ? MAX_CORES : 32'(core_count_q);
      share = (1 << SPACE_W) / cores;
      if (32'(local_addr) >= share || 32'(core) >= cores) begin
         r.address_error = 1'b1;
      end else begin
         global_addr = 32'(local_addr) + 32'(core) * share;
         word_idx = (global_addr >> 2) % WORDS_TOTAL;
         row = (word_idx / WORDS_PER_ROW) % ROW_COUNT;
         if (!row_open_q || row != 32'(open_row_q)) begin
            // write back the old row first, if there was one
            if (row_open_q) lat += 32'(row_delay_q);
            lat += 32'(row_delay_q);
            open_row_q = 10'(row);
            row_open_q = 1'b1;
            activations_q = activations_q + 1;
            r.row_activated = 1'b1;
         end
         lat += 32'(col_delay_q);
         if (op == OP_LOAD) begin
            r.read_data = shadow_words.exists(word_idx) ? shadow_words[word_idx] : '0;
         end else begin
            shadow_words[word_idx] = data;
            stores_q = stores_q + 1;
         end
      end
      r.latency = LAT_W'(lat);
      r.activation_count = activations_q;
      r.store_count = stores_q;
      return r;
   endfunction

   always @(posedge clock) begin
      access_result_type want;
      access_result_type got;
      if (reset) begin
         row_delay_q = RST_ROW_DELAY;
         col_delay_q = RST_COL_DELAY;
         core_count_q = RST_CORE_COUNT;
         open_row_q = '0;
         row_open_q = 1'b0;
         activations_q = '0;
         stores_q = '0;
         shadow_words.delete();
         pending_results.delete();
         mismatch_tally = 0;
         response_tally = 0;
         reject_tally = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_ROW_DELAY:  row_delay_q = csr_write_data[DELAY_W-1:0];
               REG_COL_DELAY:  col_delay_q = csr_write_data[DELAY_W-1:0];
               REG_CORE_COUNT: core_count_q = csr_write_data[CORES_W-1:0];
               default: ;
            endcase
         end
         // responses first: a response never belongs to a beat of the same edge
         if (rsp_valid && rsp_ready) begin
            response_tally++;
            got = '{rsp_read_data, rsp_latency, rsp_row_activated, rsp_address_error,
                    rsp_activation_count, rsp_store_count};
            if (pending_results.size() == 0) begin
               mismatch_tally++;
               if (mismatch_tally <= 10)
                  $display("tb_top: response beat %0d arrived with nothing outstanding",
                           response_tally);
            end else begin
               want = pending_results.pop_front();
               if (want.address_error) reject_tally++;
               if (got !== want) begin
                  mismatch_tally++;
                  if (mismatch_tally <= 10) begin
                     $display("tb_top: mismatch on response beat %0d", response_tally);
                     $display("   read_data exp %h got %h, latency exp %0d got %0d",
                              want.read_data, got.read_data, want.latency, got.latency);
                     $display("   row_activated exp %b got %b, address_error exp %b got %b",
                              want.row_activated, got.row_activated,
                              want.address_error, got.address_error);
                     $display("   activations exp %0d got %0d, stores exp %0d got %0d",
                              want.activation_count, got.activation_count,
                              want.store_count, got.store_count);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            pending_results.insert(pending_results.size(),
                                   predict_access(req_op, req_core_id, req_local_address,
                                                  req_store_data));
      end
      mismatches     <= mismatch_tally;
      outstanding    <= pending_results.size();
      responses      <= response_tally;
      address_errors <= reject_tally;
      row_opens      <= activations_q;
      stores_done    <= stores_q;
   end

endmodule

@@ verif/tb_top.sv @@
// tb_top: stimulus and verdict for dram_open_row_access_model
// depends on dorm_pkg, the block itself and dorm_access_checker beside it
module tb_top;
   import dorm_pkg::*;

   // no beat for this long means a hang; the limit also outlasts the clearing
   // pass after reset, which writes every word of the memory
   localparam int WATCHDOG_LIMIT = 1500000;
   localparam int LONG_HOLD      = 500;   // receiver hold-off, cycles
   localparam int PHASE_ITEMS    = 255;
   localparam int DRAIN_CYCLES   = 16;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = REG_ROW_DELAY;
   logic [CSR_DAT_W-1:0]    csr_write_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_op = OP_LOAD;
   logic [CORE_W-1:0]       req_core_id = '0;
   logic [SPACE_W-1:0]      req_local_address = '0;
   logic signed [DATA_W-1:0] req_store_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_read_data;
   logic [LAT_W-1:0]        rsp_latency;
   logic                    rsp_row_activated;
   logic                    rsp_address_error;
   logic [COUNT_W-1:0]      rsp_activation_count;
   logic [COUNT_W-1:0]      rsp_store_count;

   int mismatches;
   int outstanding;
   int responses;
   int address_errors;
   int row_opens;
   int stores_done;

   // stimulus-side view of the configuration and access locality
   logic steady = 1'b0;        // no random idling on either side while set
   int unsigned cur_cores = 1;
   int settings = 1;
   int unsigned hot_core = 0;
   int unsigned hot_base = 0;
   int unsigned stored_core [$];
   int unsigned stored_loc [$];
   int idle_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   dram_open_row_access_model u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_core_id          (req_core_id),
      .req_local_address    (req_local_address),
      .req_store_data       (req_store_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_read_data        (rsp_read_data),
      .rsp_latency          (rsp_latency),
      .rsp_row_activated    (rsp_row_activated),
      .rsp_address_error    (rsp_address_error),
      .rsp_activation_count (rsp_activation_count),
      .rsp_store_count      (rsp_store_count)
   );

   dorm_access_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_core_id          (req_core_id),
      .req_local_address    (req_local_address),
      .req_store_data       (req_store_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_read_data        (rsp_read_data),
      .rsp_latency          (rsp_latency),
      .rsp_row_activated    (rsp_row_activated),
      .rsp_address_error    (rsp_address_error),
      .rsp_activation_count (rsp_activation_count),
      .rsp_store_count      (rsp_store_count),
      .mismatches           (mismatches),
      .outstanding          (outstanding),
      .responses            (responses),
      .address_errors       (address_errors),
      .row_opens            (row_opens),
      .stores_done          (stores_done)
   );

   // idle stretch length: mostly short, now and then long
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // one request beat: optional gap, then hold valid until accepted
   // called at a rising edge, returns at the edge of acceptance
   task automatic offer(input logic op, input logic [CORE_W-1:0] core,
                        input logic [SPACE_W-1:0] addr, input logic [DATA_W-1:0] data);
      int gap;
      gap = (!steady && $urandom_range(0, 99) < 45) ? idle_span() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_core_id       <= core;
      req_local_address <= addr;
      req_store_data    <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // wait for the block to go quiet, then write all three registers
   task automatic reconfigure(input logic [CSR_DAT_W-1:0] row_d,
                              input logic [CSR_DAT_W-1:0] col_d,
                              input logic [CSR_DAT_W-1:0] cores_v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_ROW_DELAY;
      csr_write_data   <= row_d;
      @(posedge clock);
      csr_index        <= REG_COL_DELAY;
      csr_write_data   <= col_d;
      @(posedge clock);
      csr_index        <= REG_CORE_COUNT;
      csr_write_data   <= cores_v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      // 0 acts as one core, anything above 16 as 16
      cur_cores = (cores_v[CORES_W-1:0] == 0) ? 1 :
                  (cores_v[CORES_W-1:0] > MAX_CORES) ? MAX_CORES :
                  int'(cores_v[CORES_W-1:0]);
      settings++;
      // locality from the old split means nothing under the new one
      hot_core = 0;
      hot_base = 0;
      stored_core.delete();
      stored_loc.delete();
   endtask

   // random access: mostly row hits around a hot spot and read-backs of
   // recent stores, with some fully random valid ones and some noise
   task automatic offer_random();
      int unsigned share;
      int unsigned pick;
      int unsigned core;
      int unsigned loc;
      int unsigned slot;
      logic op;
      share = (1 << SPACE_W) / cur_cores;
      pick  = $urandom_range(0, 99);
      op    = $urandom_range(0, 1) ? OP_STORE : OP_LOAD;
      if (pick < 10) begin
         // noise: any core, any address, mostly rejected at high core counts
         core = $urandom_range(0, 15);
         loc  = $urandom_range(0, (1 << SPACE_W) - 1);
      end else if (pick < 35 && stored_loc.size() > 0) begin
         // revisit a recent store, low address bits scrambled
         slot = $urandom_range(0, stored_loc.size() - 1);
         core = stored_core[slot];
         loc  = (stored_loc[slot] & ~32'd3) | $urandom_range(0, 3);
      end else if (pick < 45) begin
         core = $urandom_range(0, cur_cores - 1);
         loc  = $urandom_range(0, share - 1);
      end else begin
         if ($urandom_range(0, 99) < 15) begin
            hot_core = $urandom_range(0, cur_cores - 1);
            hot_base = $urandom_range(0, share - 1) & ~32'd1023;
         end
         core = hot_core;
         loc  = hot_base + $urandom_range(0, 1023);
         if (loc >= share) loc = share - 1;
      end
      if (op == OP_STORE && core < cur_cores && loc < share) begin
         stored_core.insert(stored_core.size(), core);
         stored_loc.insert(stored_loc.size(), loc);
         if (stored_loc.size() > 32) begin
            void'(stored_core.pop_front());
            void'(stored_loc.pop_front());
         end
      end
      offer(op, CORE_W'(core), SPACE_W'(loc), $urandom());
   endtask

   // receiver: random stalls, long hold-offs at two points so the block
   // fills and pushes back on the request side
   initial begin : receiver
      int stall_left;
      int holds_done;
      stall_left = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (holds_done < 2 && responses >= (holds_done == 0 ? 150 : 700)) begin
            holds_done++;
            stall_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (steady || $urandom_range(0, 99) < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            stall_left = idle_span() - 1;
            rsp_ready <= 1'b0;
         end
      end
   end

   // watchdog over cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: timeout, no beat for %0d cycles", idle_cycles);
         $display("tb_top: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: cold open, unaligned accesses, writeback on row
      // change, top of the space, core beyond count
      offer(OP_LOAD,  4'd0,  20'h00000, 32'h0000_0000);
      offer(OP_STORE, 4'd0,  20'h00000, 32'h7FFF_FFFF);
      offer(OP_LOAD,  4'd0,  20'h00003, 32'hFFFF_FFFF);
      offer(OP_STORE, 4'd0,  20'hFFFFF, 32'h8000_0000);
      offer(OP_LOAD,  4'd0,  20'hFFFFC, 32'h0000_0000);
      offer(OP_STORE, 4'd0,  20'h00400, 32'hFFFF_FFFF);
      offer(OP_LOAD,  4'd0,  20'h00404, 32'h0000_0000);
      offer(OP_LOAD,  4'd1,  20'h00000, 32'h0000_0000);
      offer(OP_STORE, 4'd15, 20'hFFFFF, 32'h1234_5678);

      // longest delays with an uneven three-way split: top of a share,
      // one past it, core beyond count
      reconfigure(10'd1023, 10'd1023, 10'd3);
      offer(OP_LOAD,  4'd2,  20'h55554, 32'h0000_0000);
      offer(OP_STORE, 4'd0,  20'h55555, 32'hDEAD_BEEF);
      offer(OP_LOAD,  4'd3,  20'h00000, 32'h0000_0000);

      // zero delays, sixteen cores: last word of the space, one past a share
      reconfigure(10'd0, 10'd0, 10'd16);
      offer(OP_STORE, 4'd15, 20'h0FFFF, 32'h5A5A_A5A5);
      offer(OP_LOAD,  4'd15, 20'h0FFFC, 32'h0000_0000);
      offer(OP_LOAD,  4'd0,  20'h10000, 32'h0000_0000);

      // core count 0 acts as one core
      reconfigure(10'd5, 10'd1, 10'd0);
      offer(OP_LOAD,  4'd0,  20'h00400, 32'h0000_0000);
      offer(OP_LOAD,  4'd1,  20'h00000, 32'h0000_0000);

      // core count above sixteen acts as sixteen, upper data bits ignored
      reconfigure(10'd3, 10'd4, 10'h3FF);
      offer(OP_LOAD,  4'd15, 20'h0FFFF, 32'h0000_0000);
      offer(OP_LOAD,  4'd8,  20'h00000, 32'h0000_0000);

      // random phases, each under its own setting
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: reconfigure(10'd0, 10'd0, 10'd1);
            1: reconfigure(10'd1023, 10'd1023, 10'd16);
            2: reconfigure(CSR_DAT_W'($urandom_range(0, 1023)),
                           CSR_DAT_W'($urandom_range(0, 1023)), 10'd3);
            3: reconfigure(CSR_DAT_W'($urandom_range(0, 1023)),
                           CSR_DAT_W'($urandom_range(0, 1023)), 10'd0);
            4: reconfigure(10'd7, 10'd1, 10'd31);
            default: reconfigure(CSR_DAT_W'($urandom_range(0, 1023)),
                                 CSR_DAT_W'($urandom_range(0, 1023)),
                                 CSR_DAT_W'(32'h3E0 | $urandom_range(1, 16)));
         endcase
         // one phase runs flat out on both sides
         steady = (phase == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) offer_random();
      end

      // drain, then give any stray response time to show up
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb_top: %0d accesses under %0d register settings", responses, settings);
      $display("tb_top: %0d row opens, %0d stores, %0d rejected addresses",
               row_opens, stores_done, address_errors);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
